// ----- hw/rtl/lrukfr_pkg.sv -----
// shared types and command codes for the lru-k frame replacer
`timescale 1ns / 1ps
package lrukfr_pkg;
    typedef enum logic [1:0] {
        CMD_ACCESS = 2'd0,
        CMD_SET_EVICT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_EVICT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_RANGE = 2'd1,
        ST_NOT_EVICTABLE = 2'd2
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic latch_in;     // capture input beat, read ring state of its frame
        logic decide;       // read frame flags, resolve non-evict commands
        logic scan_start;   // reset scan index and best
        logic scan_issue;   // issue ring state read for scan index
        logic scan_slot;    // issue history read from returned ring state
        logic scan_eval;    // compare returned stamp
        logic evict_apply;  // clear the chosen victim
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_evict;
        logic scan_last;
    } dp_stat_t;
endpackage

// ----- hw/rtl/lru_k_frame_replacer_unit.sv -----
// top level of the lru-k frame replacer
// channel | dir | handshake          | payload
// input   | in  | in_valid/in_stall  | cmd, frame, evictable_value
// result  | out | out_valid/out_stall| victim_found, victim_frame, evictable_count, status
// config  | in  | k_wr_en            | k_wr_data
// access, set-evictable, remove: resolved in the decide state, result held in the out state
// evict: decide, a scan over every frame (issue, last, drain), apply, then the result in out
// the scan reads one frame's ring state and one history stamp per cycle, pipelined
// one beat in flight; a stalled result holds the input side stalled
// rst_n clears flags, count, clock and sets k to 2; ring state is qualified by the present flag
`timescale 1ns / 1ps
module lru_k_frame_replacer_unit #(
    parameter int FRAME_COUNT = 64,
    parameter int K_MAX = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic k_wr_en,
    input  logic [3:0] k_wr_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] frame,
    input  logic evictable_value,
    output logic out_valid,
    input  logic out_stall,
    output logic victim_found,
    output logic [5:0] victim_frame,
    output logic [6:0] evictable_count,
    output logic [1:0] status
);
    lrukfr_pkg::dp_cmd_t dp_cmd;
    lrukfr_pkg::dp_stat_t dp_stat;

    lrukfr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .dp_stat(dp_stat), .dp_cmd(dp_cmd)
    );

    lrukfr_datapath #(
        .FRAME_COUNT(FRAME_COUNT), .K_MAX(K_MAX), .STAMP_BITS(STAMP_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .k_wr_en(k_wr_en), .k_wr_data(k_wr_data),
        .cmd(cmd), .frame(frame), .evictable_value(evictable_value),
        .dp_cmd(dp_cmd), .dp_stat(dp_stat),
        .victim_found(victim_found), .victim_frame(victim_frame),
        .evictable_count(evictable_count), .status(status)
    );
endmodule

// ----- hw/rtl/lrukfr_datapath.sv -----
// datapath: frame tables, history memory, clock and evict scan
`timescale 1ns / 1ps
module lrukfr_datapath #(
    parameter int FRAME_COUNT = 64,
    parameter int K_MAX = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic k_wr_en,
    input  logic [3:0] k_wr_data,
    input  logic [1:0] cmd,
    input  logic [7:0] frame,
    input  logic evictable_value,
    input  lrukfr_pkg::dp_cmd_t dp_cmd,
    output lrukfr_pkg::dp_stat_t dp_stat,
    output logic victim_found,
    output logic [5:0] victim_frame,
    output logic [6:0] evictable_count,
    output logic [1:0] status
);
    localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int KW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CW = $clog2(K_MAX + 1);
    localparam int TW = $clog2(FRAME_COUNT + 1);
    localparam int AW = FW + KW;
    localparam int MW = KW + CW;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    logic [3:0] k_reg;
    logic [FRAME_COUNT-1:0] present_reg, evict_reg;
    logic [STAMP_BITS-1:0] clock_reg;
    logic [TW-1:0] total_reg;
    // ring state per frame: {head, count}, only meaningful while present
    logic [MW-1:0] meta_mem [FRAME_COUNT];
    logic [MW-1:0] meta_rd_reg;
    logic [STAMP_BITS-1:0] hist_mem [FRAME_COUNT << KW];
    logic [STAMP_BITS-1:0] rd_data_reg;

    logic [1:0] cmd_reg;
    logic [7:0] frame_reg;
    logic ev_reg;

    logic [FW-1:0] idx_reg, idx1_reg, cand_reg, best_reg;
    logic ok1_reg, cand_ok_reg, cand_inf_reg, cand_zero_reg;
    logic have_reg, best_inf_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;

    logic found_reg;
    logic [5:0] victim_reg;
    logic [1:0] status_reg;

    // effective k clamped to 1..K_MAX
    logic [CW-1:0] eff_k;
    always_comb
    begin
        if (k_reg == 4'd0)
            eff_k = CW'(1);
        else if (32'(k_reg) > K_MAX)
            eff_k = CW'(K_MAX);
        else
            eff_k = CW'(k_reg);
    end

    logic [FW-1:0] fr;
    assign fr = frame_reg[FW-1:0];
    logic in_range;
    assign in_range = 32'(frame_reg) < FRAME_COUNT;

    // ring state of the addressed frame, zero when absent
    logic [KW-1:0] d_head, head_next;
    logic [CW-1:0] d_count, count_next;
    always_comb
    begin
        d_head = present_reg[fr] ? meta_rd_reg[MW-1:CW] : '0;
        d_count = present_reg[fr] ? meta_rd_reg[CW-1:0] : '0;
        head_next = (32'(d_head) == K_MAX - 1) ? '0 : d_head + 1'b1;
        count_next = (32'(d_count) < K_MAX) ? d_count + 1'b1 : d_count;
    end

    logic acc_wr;
    assign acc_wr = dp_cmd.decide && cmd_reg == lrukfr_pkg::CMD_ACCESS && in_range;

    // scan read address: ring slot head - back, wrapped at K_MAX
    logic [CW-1:0] s_cnt, s_back;
    logic [KW-1:0] s_head;
    logic [KW:0] s_sum;
    logic s_inf;
    logic [KW-1:0] s_slot;
    always_comb
    begin
        s_cnt = meta_rd_reg[CW-1:0];
        s_head = meta_rd_reg[MW-1:CW];
        s_inf = s_cnt < eff_k;
        s_back = s_inf ? s_cnt : eff_k;
        s_sum = (KW+1)'(s_head) + (KW+1)'(K_MAX) - (KW+1)'(s_back);
        s_slot = (32'(s_sum) >= K_MAX) ? KW'(32'(s_sum) - K_MAX) : KW'(s_sum);
    end

    logic [STAMP_BITS-1:0] cand_stamp;
    assign cand_stamp = cand_zero_reg ? '0 : rd_data_reg;
    logic better;
    assign better = cand_ok_reg && (!have_reg || (cand_inf_reg && !best_inf_reg) ||
                    (cand_inf_reg == best_inf_reg && cand_stamp < best_stamp_reg));

    logic [STAMP_BITS-1:0] clock_inc;
    assign clock_inc = (clock_reg != STAMP_MAX) ? clock_reg + 1'b1 : clock_reg;

    // ring state and history memories with registered reads
    always_ff @(posedge clk)
    begin
        if (acc_wr)
        begin
            hist_mem[{fr, d_head}] <= clock_inc;
            meta_mem[fr] <= {head_next, count_next};
        end
        if (dp_cmd.latch_in)
            meta_rd_reg <= meta_mem[frame[FW-1:0]];
        else if (dp_cmd.scan_issue)
            meta_rd_reg <= meta_mem[idx_reg];
        if (dp_cmd.scan_slot)
            rd_data_reg <= hist_mem[AW'({idx1_reg, s_slot})];
    end

    // control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= 4'd2;
            present_reg <= '0;
            evict_reg <= '0;
            clock_reg <= '0;
            total_reg <= '0;
            have_reg <= 1'b0;
            ok1_reg <= 1'b0;
            cand_ok_reg <= 1'b0;
        end
        else
        begin
            if (k_wr_en)
                k_reg <= k_wr_data;
            if (dp_cmd.decide && cmd_reg != lrukfr_pkg::CMD_EVICT && in_range)
            begin
                unique case (cmd_reg)
                    lrukfr_pkg::CMD_ACCESS:
                    begin
                        clock_reg <= clock_inc;
                        present_reg[fr] <= 1'b1;
                    end
                    lrukfr_pkg::CMD_SET_EVICT:
                        if (present_reg[fr] && evict_reg[fr] != ev_reg)
                        begin
                            evict_reg[fr] <= ev_reg;
                            if (ev_reg)
                                total_reg <= total_reg + 1'b1;
                            else if (total_reg != '0)
                                total_reg <= total_reg - 1'b1;
                        end
                    lrukfr_pkg::CMD_REMOVE:
                        if (present_reg[fr] && evict_reg[fr])
                        begin
                            present_reg[fr] <= 1'b0;
                            evict_reg[fr] <= 1'b0;
                            if (total_reg != '0)
                                total_reg <= total_reg - 1'b1;
                        end
                    default: ;
                endcase
            end
            if (dp_cmd.scan_start)
            begin
                have_reg <= 1'b0;
                ok1_reg <= 1'b0;
                cand_ok_reg <= 1'b0;
            end
            if (dp_cmd.scan_issue)
                ok1_reg <= present_reg[idx_reg] && evict_reg[idx_reg];
            if (dp_cmd.scan_slot)
                cand_ok_reg <= ok1_reg;
            if (dp_cmd.scan_eval && better)
                have_reg <= 1'b1;
            if (dp_cmd.evict_apply && have_reg)
            begin
                present_reg[best_reg] <= 1'b0;
                evict_reg[best_reg] <= 1'b0;
                if (total_reg != '0)
                    total_reg <= total_reg - 1'b1;
            end
        end
    end

    // payload registers: input beat, scan pipeline, result
    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch_in)
        begin
            cmd_reg <= cmd;
            frame_reg <= frame;
            ev_reg <= evictable_value;
        end
        if (dp_cmd.scan_start)
            idx_reg <= '0;
        if (dp_cmd.scan_issue)
        begin
            idx1_reg <= idx_reg;
            idx_reg <= idx_reg + 1'b1;
        end
        if (dp_cmd.scan_slot)
        begin
            cand_reg <= idx1_reg;
            cand_inf_reg <= s_inf;
            cand_zero_reg <= (s_back == '0);
        end
        if (dp_cmd.scan_eval && better)
        begin
            best_reg <= cand_reg;
            best_inf_reg <= cand_inf_reg;
            best_stamp_reg <= cand_stamp;
        end
        if (dp_cmd.decide)
        begin
            found_reg <= 1'b0;
            victim_reg <= '0;
            if (cmd_reg != lrukfr_pkg::CMD_EVICT && !in_range)
                status_reg <= lrukfr_pkg::ST_RANGE;
            else if (cmd_reg == lrukfr_pkg::CMD_REMOVE && present_reg[fr] && !evict_reg[fr])
                status_reg <= lrukfr_pkg::ST_NOT_EVICTABLE;
            else
                status_reg <= lrukfr_pkg::ST_OK;
        end
        if (dp_cmd.evict_apply)
        begin
            found_reg <= have_reg;
            victim_reg <= have_reg ? 6'(best_reg) : 6'd0;
        end
    end

    assign dp_stat.is_evict = (cmd_reg == lrukfr_pkg::CMD_EVICT);
    assign dp_stat.scan_last = (32'(idx_reg) == FRAME_COUNT - 1);
    assign victim_found = found_reg;
    assign victim_frame = victim_reg;
    assign evictable_count = 7'(total_reg);
    assign status = status_reg;
endmodule

// ----- hw/rtl/lrukfr_ctrl.sv -----
// controller state machine for the lru-k frame replacer
`timescale 1ns / 1ps
module lrukfr_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  lrukfr_pkg::dp_stat_t dp_stat,
    output lrukfr_pkg::dp_cmd_t dp_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_ISSUE, S_LAST, S_DRAIN, S_APPLY, S_OUT
    } state_t;
    state_t state_reg;
    logic out_valid_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // command decode per state
    always_comb
    begin
        dp_cmd = '0;
        dp_cmd.latch_in = (state_reg == S_IDLE) && in_valid;
        dp_cmd.decide = (state_reg == S_DECIDE);
        dp_cmd.scan_start = (state_reg == S_DECIDE);
        dp_cmd.scan_issue = (state_reg == S_ISSUE);
        dp_cmd.scan_slot = (state_reg == S_ISSUE) || (state_reg == S_LAST);
        dp_cmd.scan_eval = (state_reg == S_ISSUE) || (state_reg == S_LAST) ||
                           (state_reg == S_DRAIN);
        dp_cmd.evict_apply = (state_reg == S_APPLY);
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_DECIDE;
                S_DECIDE:
                    if (dp_stat.is_evict)
                        state_reg <= S_ISSUE;
                    else
                    begin
                        state_reg <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                S_ISSUE:
                    if (dp_stat.scan_last)
                        state_reg <= S_LAST;
                S_LAST:
                    state_reg <= S_DRAIN;
                S_DRAIN:
                    state_reg <= S_APPLY;
                S_APPLY:
                begin
                    state_reg <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sim/lru_k_frame_replacer_unit_test.sv -----
// testbench for the lru-k frame replacer: directed and random commands against a predictor
`timescale 1ns / 1ps
module lru_k_frame_replacer_unit_test;
    localparam int FRAMES = 64;
    localparam int KMAX = 8;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic       found;
        logic [5:0] victim;
        logic [6:0] count;
        logic [1:0] st;
    } reply_t;

    logic clk;
    logic rst_n;
    logic k_wr_en;
    logic [3:0] k_wr_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] cmd;
    logic [7:0] frame;
    logic evictable_value;
    logic out_valid;
    logic out_stall;
    logic victim_found;
    logic [5:0] victim_frame;
    logic [6:0] evictable_count;
    logic [1:0] status;

    lru_k_frame_replacer_unit dut (
        .clk(clk), .rst_n(rst_n), .k_wr_en(k_wr_en), .k_wr_data(k_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .frame(frame),
        .evictable_value(evictable_value), .out_valid(out_valid), .out_stall(out_stall),
        .victim_found(victim_found), .victim_frame(victim_frame),
        .evictable_count(evictable_count), .status(status)
    );

    // predictor state
    logic [3:0]  k_reg;
    logic        present [FRAMES];
    logic        evictable [FRAMES];
    logic [31:0] stamps [FRAMES][KMAX];
    logic [2:0]  head [FRAMES];
    logic [3:0]  held [FRAMES];
    logic [31:0] access_clock;
    logic [6:0]  evict_total;

    reply_t replies_due [$];
    int mismatches;
    int beats_in;
    int beats_out;
    int evict_hits;
    int idle_cycles;
    int stall_left;
    bit calm;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic drop_frame(input int f);
        if (evictable[f] && evict_total > 0) evict_total = 7'(evict_total - 1);
        present[f] = 1'b0;
        evictable[f] = 1'b0;
        head[f] = '0;
        held[f] = '0;
    endtask

    // predict the reply for one command beat
    task automatic predict_reply(input lrukfr_pkg::cmd_t c, input logic [7:0] fr,
                                 input logic ev);
        reply_t r;
        int kk;
        int back;
        int best;
        bit have;
        bit best_inf;
        bit inf;
        logic [31:0] best_stamp;
        logic [31:0] s;
        r = '0;
        r.st = lrukfr_pkg::ST_OK;
        if (c == lrukfr_pkg::CMD_EVICT)
        begin
            kk = (k_reg < 1) ? 1 : (k_reg > KMAX) ? KMAX : int'(k_reg);
            have = 0;
            best_inf = 0;
            best_stamp = 0;
            best = 0;
            for (int f = 0; f < FRAMES; f++)
            begin
                if (!present[f] || !evictable[f]) continue;
                inf = held[f] < kk;
                back = inf ? int'(held[f]) : kk;
                s = (back == 0) ? 32'd0 : stamps[f][(head[f] + KMAX - back) % KMAX];
                if (!have || (inf && !best_inf) || (inf == best_inf && s < best_stamp))
                begin
                    have = 1;
                    best_inf = inf;
                    best_stamp = s;
                    best = f;
                end
            end
            if (have)
            begin
                drop_frame(best);
                r.found = 1'b1;
                r.victim = best[5:0];
            end
        end
        else if (fr >= FRAMES)
            r.st = lrukfr_pkg::ST_RANGE;
        else if (c == lrukfr_pkg::CMD_ACCESS)
        begin
            if (access_clock != 32'hffff_ffff) access_clock = 32'(access_clock + 1);
            present[fr] = 1'b1;
            stamps[fr][head[fr]] = access_clock;
            head[fr] = 3'(head[fr] + 1);
            if (held[fr] < KMAX) held[fr] = 4'(held[fr] + 1);
        end
        else if (c == lrukfr_pkg::CMD_SET_EVICT)
        begin
            if (present[fr] && evictable[fr] != ev)
            begin
                evictable[fr] = ev;
                if (ev) evict_total = 7'(evict_total + 1);
                else if (evict_total > 0) evict_total = 7'(evict_total - 1);
            end
        end
        else if (present[fr])
        begin
            if (evictable[fr]) drop_frame(fr);
            else r.st = lrukfr_pkg::ST_NOT_EVICTABLE;
        end
        r.count = evict_total;
        replies_due = {replies_due, r};
    endtask

    // take the input side idle, with a junk payload
    task automatic drop_input();
        in_valid <= 1'b0;
        cmd <= lrukfr_pkg::cmd_t'($urandom_range(0, 3));
        frame <= 8'($urandom);
        evictable_value <= 1'($urandom);
    endtask

    // send one command beat, idling at random before it
    task automatic send_beat(input lrukfr_pkg::cmd_t c, input logic [7:0] fr, input logic ev);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            drop_input();
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        frame <= fr;
        evictable_value <= ev;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_reply(c, fr, ev);
        beats_in++;
    endtask

    // wait for idle, then write k
    task automatic write_k(input logic [3:0] v);
        drop_input();
        while (replies_due.size() != 0) @(posedge clk);
        repeat (FRAMES + 8) @(posedge clk);
        k_wr_en <= 1'b1;
        k_wr_data <= v;
        @(posedge clk);
        k_wr_en <= 1'b0;
        k_reg = v;
    endtask

    // random result side stall bursts, none in reset or while calm
    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    // check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        reply_t exp_r;
        reply_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {victim_found, victim_frame, evictable_count, status};
            beats_out++;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end
            else
            begin
                exp_r = replies_due[0];
                replies_due.delete(0);
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("beat %0d: expected found=%0d victim=%0d count=%0d st=%0d",
                            beats_out, exp_r.found, exp_r.victim, exp_r.count, exp_r.st);
                        $display("beat %0d: got      found=%0d victim=%0d count=%0d st=%0d",
                            beats_out, got.found, got.victim, got.count, got.st);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_beat(lrukfr_pkg::CMD_EVICT, 8'd0, 1'b0);
        send_beat(lrukfr_pkg::CMD_ACCESS, 8'd255, 1'b1);
        send_beat(lrukfr_pkg::CMD_SET_EVICT, 8'd64, 1'b1);
        send_beat(lrukfr_pkg::CMD_REMOVE, 8'd200, 1'b0);
        send_beat(lrukfr_pkg::CMD_SET_EVICT, 8'd5, 1'b1);
        send_beat(lrukfr_pkg::CMD_REMOVE, 8'd5, 1'b0);
        send_beat(lrukfr_pkg::CMD_ACCESS, 8'd0, 1'b0);
        send_beat(lrukfr_pkg::CMD_ACCESS, 8'd63, 1'b0);
        send_beat(lrukfr_pkg::CMD_ACCESS, 8'd63, 1'b0);
        send_beat(lrukfr_pkg::CMD_ACCESS, 8'd0, 1'b0);
        send_beat(lrukfr_pkg::CMD_REMOVE, 8'd63, 1'b0);
        send_beat(lrukfr_pkg::CMD_SET_EVICT, 8'd0, 1'b1);
        send_beat(lrukfr_pkg::CMD_SET_EVICT, 8'd63, 1'b1);
        send_beat(lrukfr_pkg::CMD_SET_EVICT, 8'd63, 1'b1);
        send_beat(lrukfr_pkg::CMD_ACCESS, 8'd10, 1'b0);
        send_beat(lrukfr_pkg::CMD_SET_EVICT, 8'd10, 1'b1);
        send_beat(lrukfr_pkg::CMD_EVICT, 8'd255, 1'b1);
        send_beat(lrukfr_pkg::CMD_EVICT, 8'd0, 1'b0);
        send_beat(lrukfr_pkg::CMD_SET_EVICT, 8'd0, 1'b0);
        send_beat(lrukfr_pkg::CMD_REMOVE, 8'd0, 1'b0);
        send_beat(lrukfr_pkg::CMD_SET_EVICT, 8'd0, 1'b1);
        send_beat(lrukfr_pkg::CMD_REMOVE, 8'd0, 1'b0);
        send_beat(lrukfr_pkg::CMD_EVICT, 8'd0, 1'b0);
    endtask

    // mostly in-range, small frame pool so histories fill up and ties occur
    task automatic test_random(input int n);
        int sel;
        logic [7:0] fr;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            fr = ($urandom_range(0, 19) == 0) ? 8'($urandom) :
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 63)) :
                 8'($urandom_range(0, 11));
            if (sel < 45)
                send_beat(lrukfr_pkg::CMD_ACCESS, fr, 1'($urandom));
            else if (sel < 75)
                send_beat(lrukfr_pkg::CMD_SET_EVICT, fr, ($urandom_range(0, 3) != 0));
            else if (sel < 85)
                send_beat(lrukfr_pkg::CMD_REMOVE, fr, 1'($urandom));
            else
            begin
                send_beat(lrukfr_pkg::CMD_EVICT, 8'($urandom), 1'($urandom));
                evict_hits++;
            end
        end
    endtask

    task automatic test_k_settings();
        logic [3:0] ks [7] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5};
        foreach (ks[j])
        begin
            write_k(ks[j]);
            test_random(170);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        k_wr_en = 1'b0;
        k_wr_data = '0;
        in_valid = 1'b0;
        cmd = '0;
        frame = '0;
        evictable_value = 1'b0;
        calm = 0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        evict_hits = 0;
        idle_cycles = 0;
        k_reg = 4'd2;
        access_clock = '0;
        evict_total = '0;
        for (int f = 0; f < FRAMES; f++)
        begin
            present[f] = 0;
            evictable[f] = 0;
            head[f] = '0;
            held[f] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(100);
        test_k_settings();
        write_k(4'd2);
        calm = 1;
        test_random(130);

        drop_input();
        while (replies_due.size() != 0) @(posedge clk);
        repeat (FRAMES + 8) @(posedge clk);
        $display("%0d command beats sent, %0d results checked, %0d evict commands",
            beats_in, beats_out, evict_hits);
        $display("k settings 1, 8, 0, 15, 3, 9, 5 and 2 exercised with random stalls");
        if (mismatches == 0 && replies_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/lrukfr_pkg.sv
hw/rtl/lrukfr_datapath.sv
hw/rtl/lrukfr_ctrl.sv
hw/rtl/lru_k_frame_replacer_unit.sv
sim/lru_k_frame_replacer_unit_test.sv
